[design/xofd_pkg.sv]
// Shared types, constants and the CRC helper function of the XOR-keyed frame decoder.
`timescale 1ns / 1ps

package xofd_pkg;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_FOOT0,
		PH_FOOT1
	} phase_t;

	localparam logic [7:0]  MAGIC_0      = 8'hab;
	localparam logic [7:0]  MAGIC_1      = 8'hcd;
	localparam logic [7:0]  FOOTER_0     = 8'hdc;
	localparam logic [7:0]  FOOTER_1     = 8'hba;
	localparam logic [15:0] CRC_MARKER   = 16'hffff;
	localparam logic [15:0] CRC_POLY     = 16'h1021;

	localparam logic        KIND_DATA    = 1'b0;
	localparam logic        KIND_STATUS  = 1'b1;

	localparam logic [2:0]  ST_OK        = 3'd0;
	localparam logic [2:0]  ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0]  ST_BAD_LEN   = 3'd2;
	localparam logic [2:0]  ST_BAD_FOOT  = 3'd3;
	localparam logic [2:0]  ST_BAD_CRC   = 3'd4;

	localparam int          KEY_MAX      = 16;

	localparam logic [7:0] KEY_TABLE [KEY_MAX] = '{
		8'h16, 8'h6c, 8'h14, 8'he6, 8'h2e, 8'h91, 8'h0d, 8'h40,
		8'h21, 8'h35, 8'hd5, 8'h40, 8'h13, 8'h03, 8'he9, 8'h80
	};

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [2:0]  status;
		logic [7:0]  frame_length;
		logic [15:0] computed_crc;
		logic [15:0] received_crc;
		logic        last;
	} result_t;

	// CRC-16 XMODEM, one byte, MSB first
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[design/xor_obfuscated_frame_decoder_core.sv]
// Top level of the XOR-keyed frame decoder with CRC-16 XMODEM reporting.
`timescale 1ns / 1ps

// Takes one received word per cycle while in_ready is high, and parses frames
// of the form 0xab 0xcd, length, 0x00, then length key-obfuscated payload
// words and two obfuscated CRC words, then the footer 0xdc 0xba. Each decoded
// payload word leaves at once with kind 0; a frame ends in one status word
// with kind 1 and last set (0 ok, 1 bad magic, 2 nonzero fourth header word,
// 3 bad footer, 4 CRC field not the 0xffff marker). Header words (but a
// failing fourth one), CRC words and the first footer word give no output
// word. Throughput is one word per cycle while the output is not stalled.
// The single decode stage between the input and output registers holds
// the one byte CRC-16 update (eight XOR-shift steps), which sets the cycle.
// KEY_BYTES (1 to 16) selects how many leading key bytes repeat.
module xor_obfuscated_frame_decoder_core #(
	parameter int KEY_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  data,
	output logic [2:0]  status,
	output logic [7:0]  frame_length,
	output logic [15:0] computed_crc,
	output logic [15:0] received_crc,
	output logic        last
);

	// input register
	logic              valid_s1;
	logic [7:0]        byte_s1;

	// decode stage
	logic              res_valid;
	xofd_pkg::result_t res;
	logic              step;
	logic              can_go;

	// output register
	logic              out_valid_q;
	xofd_pkg::result_t res_q;

	// Advance the decode stage when it yields nothing or the output
	// register is free or being emptied this cycle.
	assign can_go   = !res_valid || !out_valid_q || out_ready;
	assign step     = valid_s1 && can_go;
	assign in_ready = !valid_s1 || can_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the word while the stage is stalled
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	xofd_fsm #(
		.KEY_BYTES(KEY_BYTES)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_in  (byte_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// Load a new output word, or drop the current one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign data         = res_q.data;
	assign status       = res_q.status;
	assign frame_length = res_q.frame_length;
	assign computed_crc = res_q.computed_crc;
	assign received_crc = res_q.received_crc;
	assign last         = res_q.last;

`ifndef SYNTHESIS
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1)
		else $error("decode stage lost a stalled word");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> out_valid)
		else $error("decoded result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |-> !out_valid_q || out_ready)
		else $error("output word overwritten before it was taken");

	a_data_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == xofd_pkg::KIND_DATA |-> !last && status == xofd_pkg::ST_OK)
		else $error("payload word carries status fields");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == xofd_pkg::KIND_STATUS |-> last && data == 8'd0)
		else $error("status word malformed");
`endif

endmodule

[design/xofd_fsm.sv]
// Frame parsing state machine: header check, de-keying, CRC and footer check.
`timescale 1ns / 1ps

module xofd_fsm #(
	parameter int KEY_BYTES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            byte_in,
	output logic                  res_valid,
	output xofd_pkg::result_t     res
);

	xofd_pkg::phase_t phase_q, phase_d;
	logic        fault_q, fault_d;
	logic [7:0]  len_q, len_d;
	logic [8:0]  idx_q, idx_d;
	logic [3:0]  key_idx_q, key_idx_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] field_q, field_d;
	logic        foot_ok_q, foot_ok_d;

	logic [7:0]  dec;
	logic        in_payload;
	logic        at_crc_lo;
	logic [3:0]  key_next;

	assign dec        = byte_in ^ xofd_pkg::KEY_TABLE[key_idx_q];
	assign in_payload = idx_q < {1'b0, len_q};
	assign at_crc_lo  = idx_q == {1'b0, len_q};
	assign key_next   = (key_idx_q == 4'(KEY_BYTES - 1)) ? 4'd0 : key_idx_q + 4'd1;

	// next state
	always_comb begin
		phase_d   = phase_q;
		fault_d   = fault_q;
		len_d     = len_q;
		idx_d     = idx_q;
		key_idx_d = key_idx_q;
		crc_d     = crc_q;
		field_d   = field_q;
		foot_ok_d = foot_ok_q;
		unique case (phase_q)
			xofd_pkg::PH_HEADER: begin
				unique case (idx_q[1:0])
					2'd0: begin
						fault_d = byte_in != xofd_pkg::MAGIC_0;
						idx_d   = 9'd1;
					end
					2'd1: begin
						if (byte_in != xofd_pkg::MAGIC_1) begin
							fault_d = 1'b1;
						end
						idx_d = 9'd2;
					end
					2'd2: begin
						len_d = byte_in;
						idx_d = 9'd3;
					end
					default: begin
						idx_d     = 9'd0;
						key_idx_d = 4'd0;
						crc_d     = 16'd0;
						field_d   = 16'd0;
						foot_ok_d = 1'b0;
						if (fault_q) begin
							fault_d = 1'b0;
						end else if (byte_in == 8'd0) begin
							phase_d = xofd_pkg::PH_BODY;
						end
					end
				endcase
			end
			xofd_pkg::PH_BODY: begin
				if (in_payload) begin
					crc_d     = xofd_pkg::crc_step(crc_q, dec);
					idx_d     = idx_q + 9'd1;
					key_idx_d = key_next;
				end else if (at_crc_lo) begin
					field_d   = {field_q[15:8], dec};
					idx_d     = idx_q + 9'd1;
					key_idx_d = key_next;
				end else begin
					field_d = {dec, field_q[7:0]};
					idx_d   = 9'd0;
					phase_d = xofd_pkg::PH_FOOT0;
				end
			end
			xofd_pkg::PH_FOOT0: begin
				foot_ok_d = byte_in == xofd_pkg::FOOTER_0;
				phase_d   = xofd_pkg::PH_FOOT1;
			end
			xofd_pkg::PH_FOOT1: begin
				phase_d   = xofd_pkg::PH_HEADER;
				idx_d     = 9'd0;
				fault_d   = 1'b0;
				foot_ok_d = 1'b0;
			end
			default: begin
				phase_d = xofd_pkg::PH_HEADER;
			end
		endcase
	end

	// outputs
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = xofd_pkg::KIND_DATA;
		res.data           = 8'd0;
		res.status         = xofd_pkg::ST_OK;
		res.frame_length   = len_q;
		res.computed_crc   = 16'd0;
		res.received_crc   = 16'd0;
		res.last           = 1'b0;
		unique case (phase_q)
			xofd_pkg::PH_HEADER: begin
				if (idx_q[1:0] == 2'd3) begin
					if (fault_q) begin
						res_valid  = 1'b1;
						res.kind   = xofd_pkg::KIND_STATUS;
						res.status = xofd_pkg::ST_BAD_MAGIC;
						res.last   = 1'b1;
					end else if (byte_in != 8'd0) begin
						res_valid  = 1'b1;
						res.kind   = xofd_pkg::KIND_STATUS;
						res.status = xofd_pkg::ST_BAD_LEN;
						res.last   = 1'b1;
					end
				end
			end
			xofd_pkg::PH_BODY: begin
				if (in_payload) begin
					res_valid = 1'b1;
					res.data  = dec;
				end
			end
			xofd_pkg::PH_FOOT0: begin
				res_valid = 1'b0;
			end
			xofd_pkg::PH_FOOT1: begin
				res_valid        = 1'b1;
				res.kind         = xofd_pkg::KIND_STATUS;
				res.computed_crc = crc_q;
				res.received_crc = field_q;
				res.last         = 1'b1;
				if (!(foot_ok_q && byte_in == xofd_pkg::FOOTER_1)) begin
					res.status = xofd_pkg::ST_BAD_FOOT;
				end else if (field_q != xofd_pkg::CRC_MARKER) begin
					res.status = xofd_pkg::ST_BAD_CRC;
				end else begin
					res.status = xofd_pkg::ST_OK;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= xofd_pkg::PH_HEADER;
			fault_q   <= 1'b0;
			len_q     <= 8'd0;
			idx_q     <= 9'd0;
			key_idx_q <= 4'd0;
			crc_q     <= 16'd0;
			field_q   <= 16'd0;
			foot_ok_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			fault_q   <= fault_d;
			len_q     <= len_d;
			idx_q     <= idx_d;
			key_idx_q <= key_idx_d;
			crc_q     <= crc_d;
			field_q   <= field_d;
			foot_ok_q <= foot_ok_d;
		end
	end

endmodule
